// ===== sv/news_pkg.sv =====
// Shared types and constants for the nested event word swapper.
`default_nettype none
package news_pkg;
  localparam int unsigned MaxDepth = 16;
  localparam int unsigned LvlW = $clog2(MaxDepth);

  typedef enum logic [1:0] {
    PH_TOP   = 2'd0,
    PH_BANK2 = 2'd1,
    PH_BODY  = 2'd2,
    PH_SKIP  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERRUN   = 2'd1,
    ST_TOO_DEEP  = 2'd2,
    ST_COMPOSITE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    XF_NONE  = 2'd0,
    XF_ALL   = 2'd1,
    XF_HALF  = 2'd2
  } xform_e;

  // one result as decided by the front part
  typedef struct packed {
    logic [31:0] word;
    xform_e      xf;
    logic        eoe;
    status_e     st;
  } res_t;

  // one queue entry: up to two results
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } qent_t;

  function automatic logic [31:0] swap_all(input logic [31:0] x);
    swap_all = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] swap_halves(input logic [31:0] x);
    swap_halves = {x[23:16], x[31:24], x[7:0], x[15:8]};
  endfunction
endpackage
`default_nettype wire

// ===== sv/news_front.sv =====
// Front part: header decoding, container stack and per-word classification.
`default_nettype none
module news_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              to_local_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [31:0]       in_word_i,
  output logic                   q_push_o,
  output news_pkg::qent_t        q_data_o,
  input  wire logic              q_full_i
);
  localparam int unsigned CntW = news_pkg::LvlW + 1;

  logic [31:0]              rem_q   [news_pkg::MaxDepth];
  logic [31:0]              rem_d   [news_pkg::MaxDepth];
  logic [5:0]               typ_q   [news_pkg::MaxDepth];
  logic [5:0]               typ_d   [news_pkg::MaxDepth];
  logic [CntW-1:0]          open_q, open_d;
  news_pkg::phase_e         phase_q, phase_d;
  logic [31:0]              pend_q, pend_d;
  logic [31:0]              held_q, held_d;
  logic                     hv_q, hv_d;

  logic                     fire;
  logic [31:0]              w, loc;
  logic [news_pkg::LvlW-1:0] top;
  logic [31:0]              r;
  logic [5:0]               t;
  logic [32:0]              total;
  logic [31:0]              tot32;
  logic [5:0]               ctype;
  logic                     child_open;
  logic [31:0]              child_words;
  logic                     do_settle;
  news_pkg::status_e        st;
  logic                     eoe;
  news_pkg::qent_t          ent;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign w          = in_word_i;
  assign loc        = to_local_i ? news_pkg::swap_all(w) : w;
  assign top        = open_q[news_pkg::LvlW-1:0] - 1'b1;
  assign r          = rem_q[top];
  assign t          = typ_q[top];

  always_comb begin
    news_pkg::phase_e ph;
    logic [31:0]      rem_s [news_pkg::MaxDepth];
    logic [CntW-1:0]  n;
    rem_d       = rem_q;
    typ_d       = typ_q;
    open_d      = open_q;
    pend_d      = pend_q;
    held_d      = held_q;
    hv_d        = hv_q;
    st          = news_pkg::ST_OK;
    eoe         = 1'b0;
    total       = '0;
    tot32       = '0;
    ctype       = '0;
    child_open  = 1'b0;
    child_words = '0;
    do_settle   = 1'b0;
    ent         = '0;
    ph          = phase_q;
    rem_s       = rem_q;
    n           = '0;
    if (ph == news_pkg::PH_BODY && open_q == '0) ph = news_pkg::PH_TOP;
    phase_d = ph;
    ent.r0.word = w;
    ent.r0.xf   = news_pkg::XF_ALL;
    unique case (ph)
      news_pkg::PH_TOP: begin
        if (loc == '0) begin
          st  = news_pkg::ST_OVERRUN;
          eoe = 1'b1;
        end else begin
          pend_d  = loc - 32'd1;
          phase_d = news_pkg::PH_BANK2;
        end
      end
      news_pkg::PH_BANK2: begin
        phase_d     = news_pkg::PH_BODY;
        child_open  = 1'b1;
        child_words = pend_q;
        ctype       = loc[13:8];
        do_settle   = 1'b1;
      end
      news_pkg::PH_SKIP: begin
        pend_d = pend_q - 32'd1;
        if (pend_d == '0) phase_d = news_pkg::PH_BODY;
        st        = news_pkg::ST_TOO_DEEP;
        ent.r0.xf = news_pkg::XF_NONE;
        do_settle = 1'b1;
      end
      default: begin
        do_settle = 1'b1;
        if (t == 6'he || t == 6'h10) begin
          if (loc == '0) begin
            st    = news_pkg::ST_OVERRUN;
            total = 33'd1;
          end else begin
            total = {1'b0, loc} + 33'd1;
          end
          if (total > {1'b0, r}) begin
            st    = news_pkg::ST_OVERRUN;
            total = {1'b0, r};
          end
          tot32 = total[31:0];
          rem_d[top] = r - tot32;
          if (tot32 >= 32'd2) begin
            pend_d  = tot32 - 32'd2;
            phase_d = news_pkg::PH_BANK2;
          end
        end else if (t == 6'hd || t == 6'h20 || t == 6'hc) begin
          ctype = (t == 6'hc) ? {2'b00, loc[19:16]} : loc[21:16];
          total = {17'd0, loc[15:0]} + 33'd1;
          if (total > {1'b0, r}) begin
            st    = news_pkg::ST_OVERRUN;
            total = {1'b0, r};
          end
          tot32       = total[31:0];
          rem_d[top]  = r - tot32;
          child_open  = 1'b1;
          child_words = tot32 - 32'd1;
        end else if (t == 6'h8 || t == 6'h9 || t == 6'ha) begin
          rem_d[top] = r - 32'd1;
          if (hv_q) begin
            hv_d        = 1'b0;
            ent.two     = 1'b1;
            ent.r1.word = held_q;
            ent.r1.xf   = news_pkg::XF_ALL;
          end else if (r > 32'd1) begin
            held_d    = w;
            hv_d      = 1'b1;
            do_settle = 1'b0;
          end else begin
            ent.r0.xf = news_pkg::XF_NONE;
          end
        end else begin
          rem_d[top] = r - 32'd1;
          if (t == 6'h1 || t == 6'h2 || t == 6'hb) ent.r0.xf = news_pkg::XF_ALL;
          else if (t == 6'h4 || t == 6'h5) ent.r0.xf = news_pkg::XF_HALF;
          else begin
            ent.r0.xf = news_pkg::XF_NONE;
            if (t == 6'hf) st = news_pkg::ST_COMPOSITE;
          end
        end
      end
    endcase
    if (child_open && child_words != '0) begin
      if (open_q >= CntW'(news_pkg::MaxDepth)) begin
        if (st == news_pkg::ST_OK) st = news_pkg::ST_TOO_DEEP;
        phase_d = news_pkg::PH_SKIP;
        pend_d  = child_words;
      end else begin
        rem_d[open_q[news_pkg::LvlW-1:0]] = child_words;
        typ_d[open_q[news_pkg::LvlW-1:0]] = ctype;
        open_d  = open_q + 1'b1;
        phase_d = news_pkg::PH_BODY;
      end
    end
    // pop every exhausted level: popping stops at the highest nonzero open
    // level, so the new depth is that level + 1
    if (do_settle && phase_d == news_pkg::PH_BODY) begin
      rem_s = rem_d;
      for (int i = 0; i < news_pkg::MaxDepth; i++) begin
        if (CntW'(i) < open_d && rem_s[i] != '0) n = CntW'(i + 1);
      end
      open_d = n;
      if (n == '0) begin
        phase_d = news_pkg::PH_TOP;
        hv_d    = 1'b0;
        eoe     = 1'b1;
      end
    end
    if (ent.two) begin
      ent.r1.eoe = eoe;
    end else begin
      ent.r0.eoe = eoe;
      ent.r0.st  = st;
    end
  end

  assign q_push_o = fire && !(hv_d && !hv_q);
  assign q_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < news_pkg::MaxDepth; i++) begin
        rem_q[i] <= '0;
        typ_q[i] <= '0;
      end
      open_q  <= '0;
      phase_q <= news_pkg::PH_TOP;
      pend_q  <= '0;
      held_q  <= '0;
      hv_q    <= 1'b0;
    end else if (fire) begin
      rem_q   <= rem_d;
      typ_q   <= typ_d;
      open_q  <= open_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      held_q  <= held_d;
      hv_q    <= hv_d;
    end
  end
endmodule
`default_nettype wire

// ===== sv/news_queue.sv =====
// Two-entry queue between the front and back parts.
`default_nettype none
module news_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire news_pkg::qent_t data_i,
  output logic                 full_o,
  output logic                 valid_o,
  output news_pkg::qent_t      data_o,
  input  wire logic            pop_i
);
  news_pkg::qent_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// ===== sv/news_back.sv =====
// Back part: applies the byte swaps and hands results out one per cycle while the receiver is ready.
`default_nettype none
module news_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire news_pkg::qent_t q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [31:0]          out_word_o,
  output logic                 end_of_event_o,
  output logic [1:0]           status_o
);
  logic            second_q;
  logic            load;
  news_pkg::res_t  sel;
  logic [31:0]     conv;

  assign sel = second_q ? q_data_i.r1 : q_data_i.r0;

  always_comb begin
    unique case (sel.xf)
      news_pkg::XF_ALL:  conv = news_pkg::swap_all(sel.word);
      news_pkg::XF_HALF: conv = news_pkg::swap_halves(sel.word);
      default:           conv = sel.word;
    endcase
  end

  assign load    = q_valid_i && (!out_valid_o || out_ready_i);
  assign q_pop_o = load && (second_q || !q_data_i.two);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_o     <= conv;
      end_of_event_o <= sel.eoe;
      status_o       <= sel.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (load) second_q <= q_data_i.two && !second_q;
    end
  end
endmodule
`default_nettype wire

// ===== sv/nested_event_word_swapper.sv =====
// Top level of the nested event word swapper.
// Input channel: one 32-bit event word per transaction (in_valid_i/in_ready_o).
// Output channel: converted word with end_of_event and status
//   (out_valid_o/out_ready_i), registered.
// Config channel: cfg_valid_i/cfg_ready_o writes to_local (reset 1); write it
//   only while the block is idle.
// The front part decodes headers and the container stack and takes one word
// per cycle while the queue is not full; a two-entry queue feeds the back
// part, which swaps bytes and drives the output register. A word passes
// through the queue and then the output register. Throughput is one word per
// cycle while the receiver is ready; the second word of a 64-bit pair produces
// two results, which the back part hands out one after the other. The first
// word of a pair produces no result.
// Reset empties the queue and output, closes all containers and expects a
// top bank length word next.
`default_nettype none
module nested_event_word_swapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_word_o,
  output logic             end_of_event_o,
  output logic [1:0]       status_o
);
  logic            to_local_q;
  logic            push, full, qv, pop;
  news_pkg::qent_t qin, qout;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) to_local_q <= 1'b1;
    else if (cfg_valid_i) to_local_q <= cfg_data_i;
  end

  news_front u_front (
    .clk_i, .rst_ni, .to_local_i(to_local_q), .in_valid_i, .in_ready_o,
    .in_word_i, .q_push_o(push), .q_data_o(qin), .q_full_i(full)
  );

  news_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(qin), .full_o(full),
    .valid_o(qv), .data_o(qout), .pop_i(pop)
  );

  news_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_data_i(qout), .q_pop_o(pop),
    .out_valid_o, .out_ready_i, .out_word_o, .end_of_event_o, .status_o
  );
endmodule
`default_nettype wire
